>>> hw/rtl/lbg_pkg.sv
// Shared types and constants for the life board generation engine.
`timescale 1ns / 1ps

package lbg_pkg;

   // Default and lower bound of the board edge length
   localparam int DEFAULT_MAX_DIM = 64;
   localparam int MIN_DIM         = 3;

   // Field widths fixed by the interface
   localparam int CFG_W     = 7;
   localparam int COORD_W   = 6;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 2;

   // Board size after reset
   localparam logic [CFG_W-1:0] RESET_COLS = 7'd50;
   localparam logic [CFG_W-1:0] RESET_ROWS = 7'd50;

   // B3/S23 neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Row store control from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic clear_all;
   } mem_ctl_type;

endpackage

>>> hw/rtl/lbg_row_mem.sv
// Row store of the board: one row word per entry, one write and one read port.
`timescale 1ns / 1ps

module lbg_row_mem #(
   parameter int MAX_DIM = lbg_pkg::DEFAULT_MAX_DIM,
   localparam int AW = $clog2(MAX_DIM)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lbg_pkg::mem_ctl_type ctl,
   input  logic [AW-1:0]        wr_addr,
   input  logic [MAX_DIM-1:0]   wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [MAX_DIM-1:0]   rd_data
);

   logic [MAX_DIM-1:0] store [MAX_DIM];
   logic [MAX_DIM-1:0] valid_ff;
   logic [MAX_DIM-1:0] rd_word_ff;
   logic               rd_valid_ff;

   // Row valid bits: a row never written since reset or clear reads as dead
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.clear_all) begin
            valid_ff <= '0;
         end else if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

>>> hw/rtl/lbg_row_unit.sv
// Next-generation row evaluator: neighbor count and B3/S23 rule for every column.
`timescale 1ns / 1ps

module lbg_row_unit #(
   parameter int MAX_DIM = lbg_pkg::DEFAULT_MAX_DIM,
   localparam int AW   = $clog2(MAX_DIM),
   localparam int SZ_W = $clog2(MAX_DIM + 1)
) (
   input  logic [MAX_DIM-1:0] above,
   input  logic [MAX_DIM-1:0] center,
   input  logic [MAX_DIM-1:0] below,
   input  logic [SZ_W-1:0]    width,
   output logic [MAX_DIM-1:0] next_row
);

   logic [AW-1:0] last_col;
   logic          above_last, center_last, below_last;

   assign last_col    = AW'(width - SZ_W'(1));
   assign above_last  = above[last_col];
   assign center_last = center[last_col];
   assign below_last  = below[last_col];

   for (genvar c = 0; c < MAX_DIM; c++) begin : g_col
      logic       al, cl, bl, ar, cr, br;
      logic       in_board, live;
      logic [3:0] count;

      assign in_board   = (SZ_W'(c) < width);

      if (c == 0) begin : g_left_wrap
         assign al = above_last;
         assign cl = center_last;
         assign bl = below_last;
      end else begin : g_left
         assign al = above[c-1];
         assign cl = center[c-1];
         assign bl = below[c-1];
      end

      if (c == MAX_DIM - 1) begin : g_right_edge
         assign ar = above[0];
         assign cr = center[0];
         assign br = below[0];
      end else begin : g_right
         logic wrap_right;
         assign wrap_right = (SZ_W'(c + 1) == width);
         assign ar = wrap_right ? above[0]  : above[c+1];
         assign cr = wrap_right ? center[0] : center[c+1];
         assign br = wrap_right ? below[0]  : below[c+1];
      end

      assign count = 4'(al) + 4'(above[c]) + 4'(ar) + 4'(cl) + 4'(cr)
                   + 4'(bl) + 4'(below[c]) + 4'(br);

      assign live = center[c]
                  ? (count == lbg_pkg::BIRTH_COUNT || count == lbg_pkg::SURVIVE_COUNT)
                  : (count == lbg_pkg::BIRTH_COUNT);

      // Columns beyond the active width keep their contents
      assign next_row[c] = in_board ? live : center[c];
   end

endmodule

>>> hw/rtl/life_board_generation_engine.sv
// Top level of the toroidal life board: command sequencer, size registers, row window.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// --------  ----------------------  ----------------------------------------------
// request   start & !busy           req_mode, req_x_pos, req_y_pos, req_new_value
// response  rsp_valid (one cycle)   rsp_cell_value, rsp_out_of_range
// config    csr_valid & csr_ready   csr_index, csr_wdata
//
// Timing: clear, unused modes and out-of-range coordinates answer in the cycle after
// the transfer; set, toggle and read go through S_CELL (row read, then write back for
// set and toggle). An advance reads the top row, then S_GEN_TOP and S_GEN_ABOVE fetch
// the top and bottom rows, then in S_GEN_ROW the shared row evaluator handles one row
// per cycle against the single row store port pair.
// Reset clears the whole board at once through per-row valid bits; no sweep.
// busy is high for the whole multi-cycle command and csr_ready is low meanwhile.
// The receiver cannot stall: each result shows for exactly one cycle.

module life_board_generation_engine #(
   parameter int MAX_DIM = lbg_pkg::DEFAULT_MAX_DIM
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lbg_pkg::MODE_W-1:0]    req_mode,
   input  logic [lbg_pkg::COORD_W-1:0]   req_x_pos,
   input  logic [lbg_pkg::COORD_W-1:0]   req_y_pos,
   input  logic                          req_new_value,
   output logic                          rsp_valid,
   output logic                          rsp_cell_value,
   output logic                          rsp_out_of_range,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lbg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lbg_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int AW   = $clog2(MAX_DIM);
   localparam int SZ_W = $clog2(MAX_DIM + 1);
   localparam int CW   = (SZ_W > lbg_pkg::CFG_W) ? SZ_W : lbg_pkg::CFG_W;

   localparam logic [lbg_pkg::MODE_W-1:0] MODE_SET     = 3'd0;
   localparam logic [lbg_pkg::MODE_W-1:0] MODE_TOGGLE  = 3'd1;
   localparam logic [lbg_pkg::MODE_W-1:0] MODE_ADVANCE = 3'd2;
   localparam logic [lbg_pkg::MODE_W-1:0] MODE_READ    = 3'd3;
   localparam logic [lbg_pkg::MODE_W-1:0] MODE_CLEAR   = 3'd4;

   localparam logic [lbg_pkg::CSR_IDX_W-1:0] CSR_COLS = 2'd0;
   localparam logic [lbg_pkg::CSR_IDX_W-1:0] CSR_ROWS = 2'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CELL,
      S_GEN_TOP,
      S_GEN_ABOVE,
      S_GEN_ROW
   } state_type;

   // Clamp a size register to the range the store supports
   function automatic logic [SZ_W-1:0] active_size(input logic [lbg_pkg::CFG_W-1:0] reg_val);
      logic [SZ_W-1:0] size;
      if (CW'(reg_val) < CW'(lbg_pkg::MIN_DIM)) begin
         size = SZ_W'(lbg_pkg::MIN_DIM);
      end else if (CW'(reg_val) > CW'(MAX_DIM)) begin
         size = SZ_W'(MAX_DIM);
      end else begin
         size = SZ_W'(reg_val);
      end
      return size;
   endfunction

   state_type                    state_ff, state_in;
   logic [SZ_W-1:0]              row_ff, row_in;
   logic [lbg_pkg::CFG_W-1:0]    cols_ff, cols_in;
   logic [lbg_pkg::CFG_W-1:0]    rows_ff, rows_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_cell_ff, rsp_cell_in;
   logic                         rsp_oor_ff, rsp_oor_in;

   logic [MAX_DIM-1:0]           top_ff, top_in;
   logic [MAX_DIM-1:0]           above_ff, above_in;
   logic [MAX_DIM-1:0]           center_ff, center_in;
   logic [AW-1:0]                x_ff, x_in;
   logic [AW-1:0]                y_ff, y_in;
   logic [lbg_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic                         value_ff, value_in;

   logic [SZ_W-1:0]              w_size, h_size;
   logic                         accept, csr_write, coord_oor, last_row, cell_bit;
   logic [MAX_DIM-1:0]           below, next_row, rd_data, wr_data, cell_word;
   logic [AW-1:0]                rd_addr, wr_addr;
   lbg_pkg::mem_ctl_type         mem_ctl;

   assign w_size    = active_size(cols_ff);
   assign h_size    = active_size(rows_ff);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign csr_write = csr_valid && csr_ready;
   assign coord_oor = (CW'(req_x_pos) >= CW'(w_size)) || (CW'(req_y_pos) >= CW'(h_size));
   assign last_row  = (SZ_W'(row_ff + SZ_W'(1)) == h_size);

   // Bottom row wraps onto the saved copy of the old top row
   assign below = last_row ? top_ff : rd_data;

   always_comb begin
      cell_bit = rd_data[x_ff];
      if (mode_ff == MODE_SET) begin
         cell_bit = value_ff;
      end else if (mode_ff == MODE_TOGGLE) begin
         cell_bit = !rd_data[x_ff];
      end
      cell_word       = rd_data;
      cell_word[x_ff] = cell_bit;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      rsp_valid_in = 1'b0;
      rsp_cell_in  = 1'b0;
      rsp_oor_in   = 1'b0;
      top_in       = top_ff;
      above_in     = above_ff;
      center_in    = center_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      mem_ctl      = '0;
      rd_addr      = '0;
      wr_addr      = '0;
      wr_data      = cell_word;

      if (csr_write) begin
         if (csr_index == CSR_COLS) begin
            cols_in = csr_wdata;
         end else if (csr_index == CSR_ROWS) begin
            rows_in = csr_wdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_mode) inside
                  MODE_SET, MODE_TOGGLE, MODE_READ: begin
                     if (coord_oor) begin
                        rsp_valid_in = 1'b1;
                        rsp_oor_in   = 1'b1;
                     end else begin
                        // Fetch the row, modify in the next cycle
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(req_y_pos);
                        x_in          = AW'(req_x_pos);
                        y_in          = AW'(req_y_pos);
                        mode_in       = req_mode;
                        value_in      = req_new_value;
                        state_in      = S_CELL;
                     end
                  end
                  MODE_ADVANCE: begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = '0;
                     row_in        = '0;
                     state_in      = S_GEN_TOP;
                  end
                  MODE_CLEAR: begin
                     mem_ctl.clear_all = 1'b1;
                     rsp_valid_in      = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CELL: begin
            mem_ctl.wr_en = (mode_ff != MODE_READ);
            wr_addr       = y_ff;
            wr_data       = cell_word;
            rsp_valid_in  = 1'b1;
            rsp_cell_in   = cell_bit;
            state_in      = S_IDLE;
         end
         S_GEN_TOP: begin
            // Old top row serves as center now and as wrap source at the end
            top_in        = rd_data;
            center_in     = rd_data;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = AW'(h_size - SZ_W'(1));
            state_in      = S_GEN_ABOVE;
         end
         S_GEN_ABOVE: begin
            above_in      = rd_data;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = AW'(1);
            state_in      = S_GEN_ROW;
         end
         S_GEN_ROW: begin
            // Write this row, slide the window down, prefetch two rows ahead
            mem_ctl.wr_en = 1'b1;
            wr_addr       = AW'(row_ff);
            wr_data       = next_row;
            above_in      = center_ff;
            center_in     = below;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = AW'(row_ff + SZ_W'(2));
            if (last_row) begin
               row_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               row_in = SZ_W'(row_ff + SZ_W'(1));
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         cols_ff      <= lbg_pkg::RESET_COLS;
         rows_ff      <= lbg_pkg::RESET_ROWS;
         rsp_valid_ff <= 1'b0;
         rsp_cell_ff  <= 1'b0;
         rsp_oor_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_cell_ff  <= rsp_cell_in;
         rsp_oor_ff   <= rsp_oor_in;
      end
   end

   // Row window and command fields hold payload only
   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      above_ff  <= above_in;
      center_ff <= center_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      mode_ff   <= mode_in;
      value_ff  <= value_in;
   end

   lbg_row_mem #(
      .MAX_DIM (MAX_DIM)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lbg_row_unit #(
      .MAX_DIM (MAX_DIM)
   ) u_row_unit (
      .above    (above_ff),
      .center   (center_ff),
      .below    (below),
      .width    (w_size),
      .next_row (next_row)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_value   = rsp_cell_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // An ignored coordinate never reports a live cell
   a_oor_dead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> !rsp_cell_value)
      else $error("out-of-range result reports a live cell");

   // The generation sweep never passes the active height
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GEN_ROW |-> row_ff < h_size)
      else $error("row counter beyond active height");

   // An advance transfer holds the block busy and gives no result next cycle
   a_adv_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_ADVANCE |=> busy && !rsp_valid)
      else $error("advance did not start a sweep");

   // The row store is written only by a cell update or the sweep
   a_wr_src: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> state_ff == S_CELL || state_ff == S_GEN_ROW)
      else $error("row store written outside a write phase");

endmodule

>>> test/life_board_generation_engine_tb.sv
// Self-checking testbench for the toroidal life board generation engine.
`timescale 1ns / 1ps

// Drive set, toggle, read, clear and advance commands into the engine.
// Predict every result with a behavioral copy of the board and check the
// results in order. Change the board size only while the engine is idle.
// Run three idle phases on the request side: light, heavy, none.

module life_board_generation_engine_tb;

   import lbg_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 7;
   localparam int DIM           = DEFAULT_MAX_DIM;
   localparam int RANDOM_ITEMS  = 1250;
   // Longest command: an advance on the tallest board, which sweeps every row
   localparam int SETTLE_CYCLES = DEFAULT_MAX_DIM + 6;

   // Command codes carried on req_mode
   localparam logic [MODE_W-1:0] MODE_SET     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SPARE5  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE6  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE7  = 3'd7;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD3 = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] x_pos;
      logic [COORD_W-1:0] y_pos;
      logic               new_value;
      bit                 hold_off;   // wait for every answer before this command
   } life_cmd_type;

   typedef struct packed {
      logic               cell_value;
      logic               out_of_range;
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] x_pos;
      logic [COORD_W-1:0] y_pos;
   } cell_result_type;

   // DUT inputs start at known values
   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic [MODE_W-1:0]    req_mode         = MODE_READ;
   logic [COORD_W-1:0]   req_x_pos        = '0;
   logic [COORD_W-1:0]   req_y_pos        = '0;
   logic                 req_new_value    = 1'b0;
   logic                 csr_valid        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_COLS;
   logic [CFG_W-1:0]     csr_wdata        = '0;

   logic                 busy;
   logic                 rsp_valid;
   logic                 rsp_cell_value;
   logic                 rsp_out_of_range;
   logic                 csr_ready;

   // Behavioral board, size registers and bookkeeping
   logic [DIM-1:0]       life_board [DIM];
   logic [CFG_W-1:0]     cols_reg;
   logic [CFG_W-1:0]     rows_reg;
   life_cmd_type         pending_cmds[$];
   cell_result_type      expected_cells[$];
   life_cmd_type         issued_cmd;
   int                   queued_count   = 0;
   int                   accepted_count = 0;
   int                   mismatch_count = 0;
   int                   idle_pct       = 12;

   life_board_generation_engine dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_new_value    (req_new_value),
      .rsp_valid        (rsp_valid),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Register values below the minimum or above the store size act as the bound
   function automatic int effective_dim(input logic [CFG_W-1:0] raw);
      if (raw < MIN_DIM)
         return MIN_DIM;
      if (raw > DIM)
         return DIM;
      return int'(raw);
   endfunction

   // Apply one command to the board copy and return the answer it gives
   function automatic cell_result_type apply_board_command(input life_cmd_type cmd);
      cell_result_type res;
      logic [DIM-1:0]  old_board [DIM];
      int              w, h, r, c, dr, dc, n;
      w                = effective_dim(cols_reg);
      h                = effective_dim(rows_reg);
      res.cell_value   = 1'b0;
      res.out_of_range = 1'b0;
      res.mode         = cmd.mode;
      res.x_pos        = cmd.x_pos;
      res.y_pos        = cmd.y_pos;
      case (cmd.mode)
         MODE_ADVANCE: begin
            // Count from the old generation only; cells off the active board stay put
            old_board = life_board;
            for (r = 0; r < h; r++) begin
               for (c = 0; c < w; c++) begin
                  n = 0;
                  for (dr = -1; dr <= 1; dr++)
                     for (dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                           n += old_board[(r + dr + h) % h][(c + dc + w) % w];
                  if (old_board[r][c])
                     life_board[r][c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
                  else
                     life_board[r][c] = (n == BIRTH_COUNT);
               end
            end
         end
         MODE_CLEAR: begin
            for (r = 0; r < DIM; r++)
               life_board[r] = '0;
         end
         MODE_SET, MODE_TOGGLE, MODE_READ: begin
            if (cmd.x_pos >= w || cmd.y_pos >= h) begin
               res.out_of_range = 1'b1;
            end else begin
               if (cmd.mode == MODE_SET)
                  life_board[cmd.y_pos][cmd.x_pos] = cmd.new_value;
               else if (cmd.mode == MODE_TOGGLE)
                  life_board[cmd.y_pos][cmd.x_pos] = ~life_board[cmd.y_pos][cmd.x_pos];
               res.cell_value = life_board[cmd.y_pos][cmd.x_pos];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic queue_cmd(input logic [MODE_W-1:0] mode, input int x, input int y,
                            input int v, input int hold);
      life_cmd_type cmd;
      cmd.mode      = mode;
      cmd.x_pos     = COORD_W'(x);
      cmd.y_pos     = COORD_W'(y);
      cmd.new_value = (v != 0);
      cmd.hold_off  = (hold != 0);
      pending_cmds.push_back(cmd);
      queued_count++;
   endtask

   // Wait for every queued command to be taken and answered, then tail_cycles more edges
   task automatic wait_until_settled(input int tail_cycles);
      while (accepted_count != queued_count || expected_cells.size() != 0)
         @(posedge clock);
      repeat (tail_cycles) @(posedge clock);
   endtask

   // One csr transfer; call at a rising edge while the engine is idle
   task automatic write_size_register(input logic [CSR_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_COLS)
         cols_reg = value;
      else if (idx == CSR_ROWS)
         rows_reg = value;
      // drop csr_valid and stay idle so the next transfer starts on a fresh edge
      @(posedge clock);
   endtask

   // Mostly small boards keep the whole board readable; edges and wide values now and then
   function automatic logic [CFG_W-1:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 72)
         return CFG_W'($urandom_range(8, 3));
      if (r < 86) begin
         case ($urandom_range(7))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd2;
            3: return 7'd3;
            4: return 7'd63;
            5: return 7'd64;
            6: return 7'd65;
            default: return 7'd127;
         endcase
      end
      return CFG_W'($urandom_range(127));
   endfunction

   // Seed a pattern, run a few generations and read back the cells around it
   task automatic queue_life_segment(input int w, input int h);
      bit small_board;
      int n_seed, gens, cx, cy, i, g, x, y;
      small_board = (w * h <= 36);
      if ($urandom_range(9) < 7)
         queue_cmd(MODE_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(1), 0);
      // bias the pattern onto the seams so the wrap gets exercised
      cx = $urandom_range(1) ? w - 2 : $urandom_range(w - 1);
      cy = $urandom_range(1) ? h - 2 : $urandom_range(h - 1);
      n_seed = small_board ? $urandom_range(w * h / 2, 2) : $urandom_range(14, 5);
      for (i = 0; i < n_seed; i++) begin
         if (small_board) begin
            x = $urandom_range(w - 1);
            y = $urandom_range(h - 1);
         end else begin
            x = (cx + $urandom_range(3)) % w;
            y = (cy + $urandom_range(3)) % h;
         end
         if ($urandom_range(4) == 0)
            queue_cmd(MODE_TOGGLE, x, y, $urandom_range(1), 0);
         else
            queue_cmd(MODE_SET, x, y, int'($urandom_range(5) != 0), 0);
      end
      // drop in one stray command, often off the board
      queue_cmd(MODE_W'($urandom_range(7)), $urandom_range(63), $urandom_range(63),
                $urandom_range(1), 0);
      gens = $urandom_range(4, 1);
      for (g = 0; g < gens; g++) begin
         queue_cmd(MODE_ADVANCE, $urandom_range(63), $urandom_range(63), $urandom_range(1),
                   int'($urandom_range(11) == 0));
         if (small_board) begin
            for (y = 0; y < h; y++)
               for (x = 0; x < w; x++)
                  queue_cmd(MODE_READ, x, y, $urandom_range(1), 0);
         end else begin
            for (i = 0; i < 12; i++)
               queue_cmd(MODE_READ, (cx + w - 1 + $urandom_range(5)) % w,
                         (cy + h - 1 + $urandom_range(5)) % h, $urandom_range(1), 0);
         end
      end
      repeat ($urandom_range(5, 2))
         queue_cmd(MODE_W'($urandom_range(7)), $urandom_range(63), $urandom_range(63),
                   $urandom_range(1), 0);
   endtask

   // Request driver: predict on each transfer, then hold, advance or idle
   always @(posedge clock) begin : request_driver
      logic taken;
      logic may_issue;
      taken = start && (busy === 1'b0);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            expected_cells.push_back(apply_board_command(issued_cmd));
            accepted_count++;
         end
         if (start && !taken) begin
            // hold the command until the engine takes it
         end else begin
            may_issue = (pending_cmds.size() != 0);
            if (may_issue && pending_cmds[0].hold_off && expected_cells.size() != 0)
               may_issue = 1'b0;
            if (may_issue && $urandom_range(99) < idle_pct)
               may_issue = 1'b0;
            if (may_issue) begin
               issued_cmd     = pending_cmds.pop_front();
               req_mode      <= issued_cmd.mode;
               req_x_pos     <= issued_cmd.x_pos;
               req_y_pos     <= issued_cmd.y_pos;
               req_new_value <= issued_cmd.new_value;
               start         <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every strobe is one transfer, matched against the oldest prediction
   always @(posedge clock) begin : result_monitor
      cell_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("result strobe with no command outstanding");
         end else begin
            want = expected_cells.pop_front();
            if (rsp_cell_value !== want.cell_value)
               report_mismatch($sformatf("mode %0d x %0d y %0d: cell_value %b, want %b",
                               want.mode, want.x_pos, want.y_pos, rsp_cell_value,
                               want.cell_value));
            if (rsp_out_of_range !== want.out_of_range)
               report_mismatch($sformatf("mode %0d x %0d y %0d: out_of_range %b, want %b",
                               want.mode, want.x_pos, want.y_pos, rsp_out_of_range,
                               want.out_of_range));
         end
      end
   end

   initial begin : stimulus
      int               seg;
      int               random_items;
      int               mark;
      logic [CFG_W-1:0] cols_raw;
      logic [CFG_W-1:0] rows_raw;
      for (seg = 0; seg < DIM; seg++)
         life_board[seg] = '0;
      cols_reg = RESET_COLS;
      rows_reg = RESET_ROWS;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 12;

      // Directed commands on the reset-size board
      queue_cmd(MODE_READ, 0, 0, 1, 0);
      // place the four corners: they touch each other across both seams
      queue_cmd(MODE_SET, 0, 0, 1, 0);
      queue_cmd(MODE_SET, 49, 49, 1, 0);
      queue_cmd(MODE_TOGGLE, 49, 0, 0, 0);
      queue_cmd(MODE_SET, 0, 49, 1, 0);
      // just past the edge, and the largest coordinates
      queue_cmd(MODE_READ, 50, 0, 0, 0);
      queue_cmd(MODE_SET, 0, 50, 1, 0);
      queue_cmd(MODE_TOGGLE, 63, 63, 1, 0);
      queue_cmd(MODE_ADVANCE, 63, 63, 1, 0);
      queue_cmd(MODE_READ, 0, 0, 0, 0);
      queue_cmd(MODE_READ, 49, 49, 0, 0);
      // kill one corner; its three live neighbors bring it back
      queue_cmd(MODE_TOGGLE, 0, 0, 0, 0);
      queue_cmd(MODE_ADVANCE, 0, 0, 0, 1);
      queue_cmd(MODE_READ, 0, 0, 1, 0);
      queue_cmd(MODE_READ, 48, 48, 1, 0);
      queue_cmd(MODE_SET, 49, 0, 0, 0);
      queue_cmd(MODE_SPARE5, 63, 63, 1, 0);
      queue_cmd(MODE_SPARE6, 63, 63, 1, 0);
      queue_cmd(MODE_SPARE7, 0, 0, 0, 0);
      queue_cmd(MODE_CLEAR, 63, 63, 1, 0);
      queue_cmd(MODE_READ, 49, 49, 0, 0);
      queue_cmd(MODE_READ, 0, 49, 0, 0);
      wait_until_settled(4);

      // Random segments, each on a fresh board size; sizes change only when idle
      random_items = 0;
      seg          = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items < RANDOM_ITEMS / 3)
            idle_pct = 12;
         else if (random_items < 2 * RANDOM_ITEMS / 3)
            idle_pct = 71;
         else
            idle_pct = 0;
         case (seg)
            0: begin cols_raw = 7'd0;   rows_raw = 7'd127; end
            1: begin cols_raw = 7'd127; rows_raw = 7'd0;   end
            2: begin cols_raw = 7'd3;   rows_raw = 7'd3;   end
            3: begin cols_raw = 7'd64;  rows_raw = 7'd64;  end
            4: begin cols_raw = 7'd2;   rows_raw = 7'd65;  end
            default: begin
               cols_raw = pick_dim();
               rows_raw = pick_dim();
            end
         endcase
         write_size_register(CSR_COLS, cols_raw);
         write_size_register(CSR_ROWS, rows_raw);
         // writes to the spare indexes must leave the size alone
         if ($urandom_range(5) == 0)
            write_size_register($urandom_range(1) ? CSR_RSVD2 : CSR_RSVD3,
                                CFG_W'($urandom_range(127)));
         mark = queued_count;
         queue_life_segment(effective_dim(cols_reg), effective_dim(rows_reg));
         random_items += queued_count - mark;
         wait_until_settled(4);
         seg++;
      end

      wait_until_settled(SETTLE_CYCLES);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog well beyond the slowest legal run
   initial begin : watchdog
      #(10_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
